[hdl/tzgt_pkg.sv]
`timescale 1ns / 1ps

package tzgt_pkg;

  localparam int TRACKED_FINGERS = 2;
  localparam int FIDX_W = (TRACKED_FINGERS > 1) ? $clog2(TRACKED_FINGERS) : 1;
  localparam int ZONE_CNT = 9;
  localparam int ZONE_W = 4;
  localparam int FINGER_W = 4;
  localparam int POS_W = 16;
  localparam int PROD_W = 23;
  localparam int STAMP_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W = 16;

  localparam logic [STAMP_W-1:0] TOUCH_WINDOW_MS = 32'd150;
  localparam logic [PROD_W-1:0] BAND_LOW = 23'd33;
  localparam logic [PROD_W-1:0] BAND_HIGH = 23'd66;
  localparam logic [PROD_W-1:0] PERCENT = 23'd100;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_MENU  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH     = 3'd0,
    REG_SCREEN_HEIGHT    = 3'd1,
    REG_HOLD_MIN_MS      = 3'd2,
    REG_SLIDE_FROM_ZONE  = 3'd3,
    REG_SLIDE_TO_ZONE    = 3'd4,
    REG_SLIDE_MIN_MS     = 3'd5,
    REG_SLIDE_MAX_MS     = 3'd6,
    REG_MENU_HOLD_MIN_MS = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [15:0] hold_min_ms;
    logic [3:0]  slide_from_zone;
    logic [3:0]  slide_to_zone;
    logic [15:0] slide_min_ms;
    logic [15:0] slide_max_ms;
    logic [15:0] menu_hold_min_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        kind;
    logic              tracked;
    logic [FIDX_W-1:0] finger_idx;
    logic [ZONE_W-1:0] zone;
    logic              menu_down;
  } entry_t;

  typedef struct packed {
    logic                menu_held;
    logic                menu_pressed;
    logic                slide_seen;
    logic [ZONE_CNT-1:0] held_zones;
    logic [ZONE_CNT-1:0] touched_zones;
  } result_t;

  // 0: below 33 percent, 1: 33..66, 2: above 66 (also for a zero size)
  function automatic logic [1:0] band_of(input logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] size);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] lo;
    logic [PROD_W-1:0] hi;
    p  = PROD_W'(pos) * PERCENT;
    lo = PROD_W'(size) * BAND_LOW;
    hi = PROD_W'(size) * (BAND_HIGH + PROD_W'(1));
    if (p < lo) begin
      return 2'd0;
    end else if (p < hi) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

endpackage

[hdl/tzgt_front.sv]
`timescale 1ns / 1ps

module tzgt_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tzgt_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [1:0]                          s_tuser,
  input  tzgt_pkg::cfg_t                      cfg,
  output logic                                q_valid,
  input  logic                                q_ready,
  output tzgt_pkg::entry_t                    q_entry
);
  import tzgt_pkg::*;

  logic        front_valid;
  entry_t      entry;
  entry_t      entry_next;
  logic [1:0]  band_x;
  logic [1:0]  band_y;
  logic [FINGER_W-1:0] finger;

  assign finger = s_tdata[5:2];

  always_comb begin
    band_x = band_of(s_tdata[21:6], cfg.screen_width);
    band_y = band_of(s_tdata[37:22], cfg.screen_height);
    entry_next.op         = s_tuser;
    entry_next.kind       = s_tdata[1:0];
    entry_next.tracked    = (finger < FINGER_W'(TRACKED_FINGERS));
    entry_next.finger_idx = finger[FIDX_W-1:0];
    entry_next.zone       = ZONE_W'(band_x) * ZONE_W'(3) + ZONE_W'(band_y) + ZONE_W'(1);
    entry_next.menu_down  = s_tdata[38];
  end

  assign s_tready = !front_valid || q_ready;
  assign q_valid  = front_valid;
  assign q_entry  = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      front_valid <= 1'b1;
    end else if (q_ready) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      entry <= entry_next;
    end
  end

endmodule

[hdl/tzgt_queue.sv]
`timescale 1ns / 1ps

module tzgt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  tzgt_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tzgt_pkg::entry_t pop_entry
);
  import tzgt_pkg::*;

  entry_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

[hdl/tzgt_back.sv]
`timescale 1ns / 1ps

module tzgt_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  tzgt_pkg::entry_t                   q_entry,
  input  tzgt_pkg::cfg_t                     cfg,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tzgt_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import tzgt_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_EVAL
  } back_state_t;

  back_state_t        state;
  logic [STAMP_W-1:0] now_ms;
  logic [STAMP_W-1:0] zone_stamp [ZONE_CNT];
  logic [ZONE_CNT-1:0] zone_valid;
  logic [ZONE_W-1:0]  finger_down_zone [TRACKED_FINGERS];
  logic [STAMP_W-1:0] finger_down_stamp [TRACKED_FINGERS];
  logic [ZONE_W-1:0]  finger_up_zone [TRACKED_FINGERS];
  logic [STAMP_W-1:0] finger_up_stamp [TRACKED_FINGERS];
  logic               menu_level;
  logic [STAMP_W-1:0] menu_stamp;
  result_t            res;
  logic [ZONE_W-1:0]  zidx;
  logic               out_free;

  assign q_ready  = (state == B_IDLE);
  assign zidx     = q_entry.zone - ZONE_W'(1);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    res = '0;
    res.menu_pressed = menu_level;
    res.menu_held = menu_level &&
                    ((now_ms - menu_stamp) >= STAMP_W'(cfg.menu_hold_min_ms));
    for (int z = 0; z < ZONE_CNT; z++) begin
      res.touched_zones[z] = zone_valid[z] && ((now_ms - zone_stamp[z]) < TOUCH_WINDOW_MS);
    end
    for (int f = 0; f < TRACKED_FINGERS; f++) begin
      for (int z = 0; z < ZONE_CNT; z++) begin
        if (finger_down_zone[f] == ZONE_W'(z + 1) &&
            finger_up_stamp[f] < finger_down_stamp[f] &&
            (now_ms - finger_down_stamp[f]) >= STAMP_W'(cfg.hold_min_ms)) begin
          res.held_zones[z] = 1'b1;
        end
      end
      if (finger_down_zone[f] == cfg.slide_from_zone &&
          finger_up_zone[f] == cfg.slide_to_zone &&
          finger_up_stamp[f] > finger_down_stamp[f] &&
          (now_ms - finger_up_stamp[f]) < TOUCH_WINDOW_MS &&
          (finger_up_stamp[f] - finger_down_stamp[f]) >= STAMP_W'(cfg.slide_min_ms) &&
          (finger_up_stamp[f] - finger_down_stamp[f]) <= STAMP_W'(cfg.slide_max_ms)) begin
        res.slide_seen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      m_tvalid   <= 1'b0;
      now_ms     <= '0;
      zone_valid <= '0;
      menu_level <= 1'b0;
      menu_stamp <= '0;
      for (int z = 0; z < ZONE_CNT; z++) begin
        zone_stamp[z] <= '0;
      end
      for (int f = 0; f < TRACKED_FINGERS; f++) begin
        finger_down_zone[f]  <= '0;
        finger_down_stamp[f] <= '0;
        finger_up_zone[f]    <= '0;
        finger_up_stamp[f]   <= '0;
      end
    end else begin
      if (state == B_EVAL && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= B_EVAL;
            case (q_entry.op)
              OP_TICK: begin
                now_ms <= now_ms + STAMP_W'(1);
              end
              OP_TOUCH: begin
                zone_stamp[zidx] <= now_ms;
                zone_valid[zidx] <= 1'b1;
                if (q_entry.tracked && q_entry.kind == KIND_DOWN) begin
                  finger_down_zone[q_entry.finger_idx]  <= q_entry.zone;
                  finger_down_stamp[q_entry.finger_idx] <= now_ms;
                end else if (q_entry.tracked && q_entry.kind == KIND_UP) begin
                  finger_up_zone[q_entry.finger_idx]  <= q_entry.zone;
                  finger_up_stamp[q_entry.finger_idx] <= now_ms;
                end
              end
              OP_MENU: begin
                menu_level <= q_entry.menu_down;
                menu_stamp <= now_ms;
              end
              default: begin
              end
            endcase
          end
        end
        B_EVAL: begin
          if (out_free) begin
            m_tdata  <= OUT_TDATA_W'(res);
            state    <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/touch_zone_gesture_tracker_top.sv]
`timescale 1ns / 1ps

// Touch zone gesture tracker.
// Input stream (s_*): one item per transfer. s_tuser is the op (tick, touch,
// menu event); s_tdata carries touch_kind, finger, x_pos, y_pos, menu_down.
// Output stream (m_*): one result per input item, in order, giving touched
// and held zone masks, slide_seen, menu_pressed and menu_held.
// Config channel (cfg_*): cfg_index selects one of eight registers, cfg_data
// holds the value; always ready. Write only while no item is in flight.
// An input item passes the front-end register, the queue and the back end's
// state update before the result is registered. The back end takes no new
// item until it has registered the result formed from the updated state.
// A 2-entry queue sits between the classifying front end and the back end.
// Reset clears all tracking state, the zone valid bits and the queue, and
// loads the register defaults. A stalled receiver holds the result; the
// front end keeps accepting until the queue and its own stage are full.
module touch_zone_gesture_tracker_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] touch_kind, [5:2] finger, [21:6] x_pos, [37:22] y_pos, [38] menu_down
  input  logic [tzgt_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] op
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [8:0] touched_zones, [17:9] held_zones, [18] slide_seen,
  // [19] menu_pressed, [20] menu_held
  output logic [tzgt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  tzgt_pkg::cfg_index_t                cfg_index,
  input  logic [tzgt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tzgt_pkg::*;

  cfg_t   cfg;
  logic   fq_valid;
  logic   fq_ready;
  entry_t fq_entry;
  logic   qb_valid;
  logic   qb_ready;
  entry_t qb_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width     <= 16'd1920;
      cfg.screen_height    <= 16'd1080;
      cfg.hold_min_ms      <= 16'd0;
      cfg.slide_from_zone  <= 4'd1;
      cfg.slide_to_zone    <= 4'd3;
      cfg.slide_min_ms     <= 16'd0;
      cfg.slide_max_ms     <= 16'd1000;
      cfg.menu_hold_min_ms <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:     cfg.screen_width     <= cfg_data;
        REG_SCREEN_HEIGHT:    cfg.screen_height    <= cfg_data;
        REG_HOLD_MIN_MS:      cfg.hold_min_ms      <= cfg_data;
        REG_SLIDE_FROM_ZONE:  cfg.slide_from_zone  <= cfg_data[3:0];
        REG_SLIDE_TO_ZONE:    cfg.slide_to_zone    <= cfg_data[3:0];
        REG_SLIDE_MIN_MS:     cfg.slide_min_ms     <= cfg_data;
        REG_SLIDE_MAX_MS:     cfg.slide_max_ms     <= cfg_data;
        REG_MENU_HOLD_MIN_MS: cfg.menu_hold_min_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tzgt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_entry  (fq_entry)
  );

  tzgt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_entry (fq_entry),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_entry  (qb_entry)
  );

  tzgt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_entry  (qb_entry),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_reset_no_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");
  a_menu_held_pressed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[20] && !m_tdata[19]))
    else $error("menu held reported without menu pressed");
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fq_valid && !fq_ready) |=> fq_valid)
    else $error("front stage dropped an item while queue was full");
`endif

endmodule
